FILE: design/rational_arithmetic_unit_macros.svh
// Assertion macros for the rational arithmetic unit.
`ifndef RATIONAL_ARITHMETIC_UNIT_MACROS_SVH
`define RATIONAL_ARITHMETIC_UNIT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define RAU_ASSERT_NOW(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);
`define RAU_ASSERT_NEXT(lbl, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) else $error(msg);
`else
`define RAU_ASSERT_NOW(lbl, cond, msg)
`define RAU_ASSERT_NEXT(lbl, pre, post, msg)
`endif
`endif

FILE: design/rau_pkg.sv
// Package with the types and codes of the rational arithmetic unit.
package rau_pkg;
	typedef enum logic [3:0] {
		ST_IDLE, ST_MUL1, ST_MUL2, ST_MUL3, ST_ADD, ST_GCD, ST_DIVN, ST_DIVD, ST_FIN
	} state_t;

	localparam logic [1:0] KIND_ADD = 2'd0;
	localparam logic [1:0] KIND_SUB = 2'd1;
	localparam logic [1:0] KIND_MUL = 2'd2;
	localparam logic [1:0] KIND_DIV = 2'd3;

	localparam logic [1:0] STATUS_OK       = 2'd0;
	localparam logic [1:0] STATUS_ZERO_DEN = 2'd1;
	localparam logic [1:0] STATUS_DIV_ZERO = 2'd2;
	localparam logic [1:0] STATUS_OVERFLOW = 2'd3;
endpackage

FILE: design/rational_arithmetic_unit.sv
// Rational arithmetic unit: fraction add, subtract, multiply and divide with reduction.
// A request is taken on a rising edge where start is high and busy is low. It carries
// kind and the two fractions; only the low OPERAND_WIDTH bits of each operand are used,
// sign-extended. busy stays high while the request is worked on and no request is taken.
// The result is shown on result_numerator, result_denominator and status for exactly one
// cycle, marked by done; the receiver cannot stall and must take it in that cycle.
// A request with a zero denominator or a division by a zero fraction gives its status
// in the cycle after the request. Otherwise the block forms three products on one shared
// multiplier, one signed add, a binary GCD that takes one shift, swap or subtract step
// per cycle, then two exact 64-step shift-subtract divisions on the same subtractor,
// and a final step to finish. Only the GCD loop makes the length of a request vary.
// Reset clears the sequencer and done; busy is low after reset.
`include "rational_arithmetic_unit_macros.svh"
module rational_arithmetic_unit #(
	parameter int OPERAND_WIDTH = 32
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic [1:0]         kind,
	input  logic signed [31:0] first_numerator,
	input  logic signed [31:0] first_denominator,
	input  logic signed [31:0] second_numerator,
	input  logic signed [31:0] second_denominator,
	output logic               done,
	output logic signed [63:0] result_numerator,
	output logic [62:0]        result_denominator,
	output logic [1:0]         status
);
	localparam int W = OPERAND_WIDTH;

	rau_pkg::state_t state_q, next_state;

	logic [1:0]   kind_q;
	logic         a_neg_q, b_neg_q, c_neg_q, d_neg_q;
	logic [W-1:0] a_mag_q, b_mag_q, c_mag_q, d_mag_q;
	logic         num_neg_q, t_neg_q, den_neg_q;
	logic [63:0]  num_q, t_q, den_q;
	logic [63:0]  ga_q, gb_q, g_q, rem_q, dq_q;
	logic [5:0]   k_q, cnt_q;
	logic         done_q;

	logic         in_a_neg, in_b_neg, in_c_neg, in_d_neg;
	logic [W-1:0] in_a_mag, in_b_mag, in_c_mag, in_d_mag;
	logic         accept, err_div_zero, err_zero_den;

	logic [W-1:0]   mul_x, mul_y;
	logic           mul_xn, mul_yn;
	logic [2*W-1:0] prod;
	logic [63:0]    prod64;
	logic           prod_neg;

	logic [63:0] sub_a, sub_b, div_sh;
	logic [64:0] sub_r;
	logic        borrow;

	logic        add_neg;
	logic [63:0] add_mag;
	logic        t_eff_neg;

	logic        fin_neg;

	assign in_a_neg = first_numerator[W-1];
	assign in_b_neg = first_denominator[W-1];
	assign in_c_neg = second_numerator[W-1];
	assign in_d_neg = second_denominator[W-1];
	assign in_a_mag = in_a_neg ? (~first_numerator[W-1:0] + 1'b1) : first_numerator[W-1:0];
	assign in_b_mag = in_b_neg ? (~first_denominator[W-1:0] + 1'b1)
		: first_denominator[W-1:0];
	assign in_c_mag = in_c_neg ? (~second_numerator[W-1:0] + 1'b1) : second_numerator[W-1:0];
	assign in_d_mag = in_d_neg ? (~second_denominator[W-1:0] + 1'b1)
		: second_denominator[W-1:0];

	assign accept       = start && !busy;
	assign err_div_zero = (kind == rau_pkg::KIND_DIV) && (second_numerator[W-1:0] == '0);
	assign err_zero_den = (first_denominator[W-1:0] == '0) || (second_denominator[W-1:0] == '0);

	assign prod     = mul_x * mul_y;
	assign prod64   = 64'(prod);
	assign prod_neg = (prod != '0) && (mul_xn != mul_yn);

	assign sub_r  = {1'b0, sub_a} - {1'b0, sub_b};
	assign borrow = sub_r[64];
	assign div_sh = {rem_q[62:0], dq_q[63]};

	assign t_eff_neg = (kind_q == rau_pkg::KIND_SUB) ? ((t_q != '0) && !t_neg_q) : t_neg_q;

	always_comb begin
		if (num_neg_q == t_eff_neg) begin
			add_mag = num_q + t_q;
			add_neg = num_neg_q;
		end else if (num_q >= t_q) begin
			add_mag = num_q - t_q;
			add_neg = num_neg_q;
		end else begin
			add_mag = t_q - num_q;
			add_neg = t_eff_neg;
		end
		if (add_mag == '0) begin
			add_neg = 1'b0;
		end
	end

	assign fin_neg = (num_q != '0) && (num_neg_q != den_neg_q);

	always_comb begin
		next_state = state_q;
		case (state_q)
			rau_pkg::ST_IDLE: begin
				if (accept && !err_div_zero && !err_zero_den) begin
					next_state = rau_pkg::ST_MUL1;
				end
			end
			rau_pkg::ST_MUL1: next_state = rau_pkg::ST_MUL2;
			rau_pkg::ST_MUL2: next_state = rau_pkg::ST_MUL3;
			rau_pkg::ST_MUL3: next_state = rau_pkg::ST_ADD;
			rau_pkg::ST_ADD:  next_state = rau_pkg::ST_GCD;
			rau_pkg::ST_GCD: begin
				if (ga_q == '0) begin
					next_state = rau_pkg::ST_DIVN;
				end
			end
			rau_pkg::ST_DIVN: begin
				if (cnt_q == 6'd63) begin
					next_state = rau_pkg::ST_DIVD;
				end
			end
			rau_pkg::ST_DIVD: begin
				if (cnt_q == 6'd63) begin
					next_state = rau_pkg::ST_FIN;
				end
			end
			rau_pkg::ST_FIN: next_state = rau_pkg::ST_IDLE;
			default: next_state = rau_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		busy   = (state_q != rau_pkg::ST_IDLE);
		mul_x  = a_mag_q;
		mul_xn = a_neg_q;
		mul_y  = d_mag_q;
		mul_yn = d_neg_q;
		sub_a  = ga_q;
		sub_b  = gb_q;
		case (state_q)
			rau_pkg::ST_MUL1: begin
				if (kind_q == rau_pkg::KIND_MUL) begin
					mul_y  = c_mag_q;
					mul_yn = c_neg_q;
				end
			end
			rau_pkg::ST_MUL2: begin
				mul_x  = c_mag_q;
				mul_xn = c_neg_q;
				mul_y  = b_mag_q;
				mul_yn = b_neg_q;
			end
			rau_pkg::ST_MUL3: begin
				mul_x  = b_mag_q;
				mul_xn = b_neg_q;
				if (kind_q == rau_pkg::KIND_DIV) begin
					mul_y  = c_mag_q;
					mul_yn = c_neg_q;
				end
			end
			rau_pkg::ST_DIVN, rau_pkg::ST_DIVD: begin
				sub_a = div_sh;
				sub_b = g_q;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= rau_pkg::ST_IDLE;
			done_q  <= 1'b0;
		end else begin
			state_q <= next_state;
			done_q  <= (accept && (err_div_zero || err_zero_den))
				|| (state_q == rau_pkg::ST_FIN);
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			rau_pkg::ST_IDLE: begin
				if (accept) begin
					kind_q  <= kind;
					a_neg_q <= in_a_neg;
					b_neg_q <= in_b_neg;
					c_neg_q <= in_c_neg;
					d_neg_q <= in_d_neg;
					a_mag_q <= in_a_mag;
					b_mag_q <= in_b_mag;
					c_mag_q <= in_c_mag;
					d_mag_q <= in_d_mag;
					result_numerator   <= '0;
					result_denominator <= '0;
					status <= err_div_zero ? rau_pkg::STATUS_DIV_ZERO
						: rau_pkg::STATUS_ZERO_DEN;
				end
			end
			rau_pkg::ST_MUL1: begin
				num_q     <= prod64;
				num_neg_q <= prod_neg;
			end
			rau_pkg::ST_MUL2: begin
				t_q     <= prod64;
				t_neg_q <= prod_neg;
			end
			rau_pkg::ST_MUL3: begin
				den_q     <= prod64;
				den_neg_q <= prod_neg;
			end
			rau_pkg::ST_ADD: begin
				if (kind_q == rau_pkg::KIND_ADD || kind_q == rau_pkg::KIND_SUB) begin
					num_q     <= add_mag;
					num_neg_q <= add_neg;
					ga_q      <= add_mag;
				end else begin
					ga_q <= num_q;
				end
				gb_q <= den_q;
				k_q  <= '0;
			end
			rau_pkg::ST_GCD: begin
				if (ga_q == '0) begin
					g_q   <= gb_q << k_q;
					rem_q <= '0;
					dq_q  <= num_q;
					cnt_q <= '0;
				end else if (!ga_q[0] && !gb_q[0]) begin
					ga_q <= ga_q >> 1;
					gb_q <= gb_q >> 1;
					k_q  <= k_q + 6'd1;
				end else if (!ga_q[0]) begin
					ga_q <= ga_q >> 1;
				end else if (!gb_q[0]) begin
					gb_q <= gb_q >> 1;
				end else if (borrow) begin
					ga_q <= gb_q;
					gb_q <= ga_q;
				end else begin
					ga_q <= sub_r[63:0];
				end
			end
			rau_pkg::ST_DIVN, rau_pkg::ST_DIVD: begin
				if (cnt_q == 6'd63) begin
					rem_q <= '0;
					cnt_q <= '0;
					if (state_q == rau_pkg::ST_DIVN) begin
						num_q <= {dq_q[62:0], !borrow};
						dq_q  <= den_q;
					end else begin
						den_q <= {dq_q[62:0], !borrow};
					end
				end else begin
					rem_q <= borrow ? div_sh : sub_r[63:0];
					dq_q  <= {dq_q[62:0], !borrow};
					cnt_q <= cnt_q + 6'd1;
				end
			end
			rau_pkg::ST_FIN: begin
				if (!fin_neg && num_q[63]) begin
					status             <= rau_pkg::STATUS_OVERFLOW;
					result_numerator   <= '0;
					result_denominator <= '0;
				end else begin
					status             <= rau_pkg::STATUS_OK;
					result_numerator   <= fin_neg ? (~num_q + 64'd1) : num_q;
					result_denominator <= den_q[62:0];
				end
			end
			default: begin
			end
		endcase
	end

	assign done = done_q;

	`RAU_ASSERT_NOW(a_done_idle, !(done && busy), "result shown while busy")
	`RAU_ASSERT_NEXT(a_accept_progress, start && !busy, busy || done, "request dropped")
	`RAU_ASSERT_NOW(a_ok_den, !(done && status == rau_pkg::STATUS_OK)
		|| (result_denominator != '0), "ok result with zero denominator")
endmodule

FILE: verif/tb.sv
// Testbench for the rational arithmetic unit with random and directed requests.
`timescale 1ns / 1ps
module tb;
	typedef struct {
		logic [1:0]         kind;
		logic signed [31:0] an, ad, bn, bd;
	} request_t;

	typedef struct {
		logic signed [63:0] num;
		logic [62:0]        den;
		logic [1:0]         status;
	} fraction_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	logic [1:0] kind = rau_pkg::KIND_ADD;
	logic signed [31:0] first_numerator = '0;
	logic signed [31:0] first_denominator = '0;
	logic signed [31:0] second_numerator = '0;
	logic signed [31:0] second_denominator = '0;
	logic done;
	logic signed [63:0] result_numerator;
	logic [62:0] result_denominator;
	logic [1:0] status;

	request_t pending_requests[$];
	fraction_t expected_fractions[$];
	int error_count = 0;
	int idle_left = 0;
	bit idle_enable = 1'b1;
	bit hold_off = 1'b0;
	bit stimulus_done = 1'b0;

	rational_arithmetic_unit dut (.*);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	function automatic fraction_t reduce_fraction(request_t r);
		fraction_t f;
		logic signed [65:0] a, b, c, d, num, den;
		logic [65:0] x, y, t, p, q;
		logic neg;
		f = '{num: '0, den: '0, status: rau_pkg::STATUS_OK};
		a = r.an; b = r.ad; c = r.bn; d = r.bd;
		if (r.kind == rau_pkg::KIND_DIV && c == 0) begin
			f.status = rau_pkg::STATUS_DIV_ZERO;
			return f;
		end
		if (b == 0 || d == 0) begin
			f.status = rau_pkg::STATUS_ZERO_DEN;
			return f;
		end
		case (r.kind)
			rau_pkg::KIND_ADD: begin num = a * d + c * b; den = b * d; end
			rau_pkg::KIND_SUB: begin num = a * d - c * b; den = b * d; end
			rau_pkg::KIND_MUL: begin num = a * c; den = b * d; end
			default:           begin num = a * d; den = b * c; end
		endcase
		neg = (num != 0) && ((num < 0) != (den < 0));
		x = (num < 0) ? -num : num;
		y = (den < 0) ? -den : den;
		p = x; q = y;
		while (q != 0) begin
			t = p % q;
			p = q;
			q = t;
		end
		x = x / p;
		y = y / p;
		if ((!neg && x > 66'h0_7FFF_FFFF_FFFF_FFFF) || (neg && x > 66'h0_8000_0000_0000_0000))
			f.status = rau_pkg::STATUS_OVERFLOW;
		else begin
			f.num = neg ? -x[63:0] : x[63:0];
			f.den = y[62:0];
		end
		return f;
	endfunction

	task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
		$display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $time);
		error_count++;
	endtask

	always @(posedge clk) begin
		if (arst_n && start && !busy) begin
			expected_fractions.push_back(reduce_fraction('{kind, first_numerator,
				first_denominator, second_numerator, second_denominator}));
			void'(pending_requests.pop_front());
		end
	end

	logic accepted_now;
	always @(posedge clk) accepted_now <= arst_n && start && !busy;

	always @(negedge clk) begin
		if (arst_n) begin
			if (idle_left > 0)
				idle_left <= idle_left - 1;
			if ((start && !accepted_now) || hold_off || idle_left > 0) begin
			end else if (idle_enable && $urandom_range(0, 15) == 0) begin
				start <= 1'b0;
				idle_left <= $urandom_range(1, 12);
			end else if (pending_requests.size() > 0) begin
				start <= 1'b1;
				kind <= pending_requests[0].kind;
				first_numerator <= pending_requests[0].an;
				first_denominator <= pending_requests[0].ad;
				second_numerator <= pending_requests[0].bn;
				second_denominator <= pending_requests[0].bd;
			end else
				start <= 1'b0;
			if ((hold_off || idle_left > 0) && accepted_now)
				start <= 1'b0;
		end
	end

	always @(posedge clk) begin
		fraction_t want;
		if (arst_n && done) begin
			if (expected_fractions.size() == 0) begin
				report_mismatch("unexpected result", {62'd0, status}, 64'd0);
			end else begin
				want = expected_fractions.pop_front();
				if (result_numerator !== want.num)
					report_mismatch("numerator", result_numerator, want.num);
				if (result_denominator !== want.den)
					report_mismatch("denominator", {1'b0, result_denominator}, {1'b0, want.den});
				if (status !== want.status)
					report_mismatch("status", {62'd0, status}, {62'd0, want.status});
			end
		end
	end

	function automatic logic [31:0] random_operand();
		case ($urandom_range(0, 5))
			0: return 32'($urandom_range(0, 20) - 10);
			1: return 32'h8000_0000 + 32'($urandom_range(0, 3));
			2: return 32'h7FFF_FFFF - 32'($urandom_range(0, 3));
			3: return 32'(($urandom_range(1, 1000)) * (1 << $urandom_range(0, 20)));
			default: return 32'($urandom());
		endcase
	endfunction

	task automatic add_request(logic [1:0] k, logic [31:0] an, logic [31:0] ad,
		logic [31:0] bn, logic [31:0] bd);
		pending_requests.push_back('{k, an, ad, bn, bd});
	endtask

	task automatic wait_drained();
		while (pending_requests.size() > 0 || start)
			@(posedge clk);
		while (expected_fractions.size() > 0)
			@(posedge clk);
	endtask

	initial begin
		request_t r;
		repeat (3) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;
		add_request(rau_pkg::KIND_ADD, 1, 2, 1, 3);
		add_request(rau_pkg::KIND_SUB, 1, 2, 1, 2);
		add_request(rau_pkg::KIND_MUL, -3, 4, 8, -9);
		add_request(rau_pkg::KIND_DIV, 5, 7, 0, 3);
		add_request(rau_pkg::KIND_DIV, 5, 0, 0, 0);
		add_request(rau_pkg::KIND_ADD, 5, 0, 1, 1);
		add_request(rau_pkg::KIND_MUL, 1, 1, 1, 0);
		add_request(rau_pkg::KIND_MUL, 32'h8000_0000, 1, 32'h8000_0000, 1);
		add_request(rau_pkg::KIND_MUL, 32'h8000_0000, 1, 32'h7FFF_FFFF, 1);
		add_request(rau_pkg::KIND_ADD, 32'h8000_0000, 1, 32'h8000_0000, 1);
		add_request(rau_pkg::KIND_SUB, 32'h7FFF_FFFF, 1, 32'h8000_0000, 1);
		add_request(rau_pkg::KIND_DIV, 32'h8000_0000, 1, 1, 32'h8000_0000);
		add_request(rau_pkg::KIND_DIV, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000,
			32'h7FFF_FFFF);
		add_request(rau_pkg::KIND_ADD, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
			32'hFFFF_FFFF);
		add_request(rau_pkg::KIND_SUB, 0, 32'h8000_0000, 0, 5);
		add_request(rau_pkg::KIND_MUL, 0, -7, 9, 3);
		add_request(rau_pkg::KIND_ADD, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
			32'h7FFF_FFFD);
		wait_drained();
		hold_off = 1'b1;
		repeat (20) @(posedge clk);
		hold_off = 1'b0;
		for (int i = 0; i < 1200; i++) begin
			r.kind = 2'($urandom_range(0, 3));
			r.an = random_operand();
			r.ad = random_operand();
			r.bn = random_operand();
			r.bd = random_operand();
			if ($urandom_range(0, 19) == 0) r.ad = 0;
			if ($urandom_range(0, 19) == 0) r.bn = 0;
			pending_requests.push_back(r);
			if (i == 1100)
				idle_enable = 1'b0;
			if (pending_requests.size() > 8)
				while (pending_requests.size() > 2)
					@(posedge clk);
		end
		idle_enable = 1'b0;
		wait_drained();
		repeat (500) @(posedge clk);
		if (error_count == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

	initial begin
		#200ms;
		$display("FAIL");
		$finish;
	end
endmodule

FILE: sim.f
+incdir+design
design/rau_pkg.sv
design/rational_arithmetic_unit.sv
verif/tb.sv
